[src/u8u16_pkg.sv]
`default_nettype none

package u8u16_pkg;

  // Replacement unit for any malformed sequence ('?').
  localparam logic [15:0] UnitErr = 16'h003F;

  // Surrogate half prefixes (top six bits of 0xD800 and 0xDC00).
  localparam logic [5:0] SurrHiPfx = 6'b110110;
  localparam logic [5:0] SurrLoPfx = 6'b110111;

  // Lead byte classes, decoded from the top five bits.
  typedef enum logic [2:0] {
    LC_CONT,
    LC_SINGLE,
    LC_TWO,
    LC_THREE,
    LC_FOUR,
    LC_BAD
  } lead_class_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_end;
    logic        string_end;
  } out_word_t;

  // Sequence state carried between bytes.
  typedef struct packed {
    logic [2:0]  bytes_left;
    logic [20:0] point_accum;
    logic        seq_bad;
  } seq_state_t;

  function automatic lead_class_e lead_class(input logic [7:0] b);
    lead_class_e c;
    if (!b[7]) begin
      c = LC_SINGLE;
    end else if (!b[6]) begin
      c = LC_CONT;
    end else if (!b[5]) begin
      c = LC_TWO;
    end else if (!b[4]) begin
      c = LC_THREE;
    end else if (!b[3]) begin
      c = LC_FOUR;
    end else begin
      c = LC_BAD;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/u8u16_decode.sv]
`default_nettype none

// Per-byte decode: next sequence state and up to two UTF-16 words.
module u8u16_decode (
  input  u8u16_pkg::in_word_t   in_word_i,
  input  u8u16_pkg::seq_state_t state_i,
  output u8u16_pkg::seq_state_t state_o,
  output logic [1:0]            n_units_o,
  output u8u16_pkg::out_word_t  unit0_o,
  output u8u16_pkg::out_word_t  unit1_o
);
  import u8u16_pkg::*;

  lead_class_e cls;
  logic [7:0]  b;
  logic        last;
  logic [20:0] accum_n;
  logic        bad_n;
  logic [2:0]  left_n;
  logic [19:0] offs;

  assign b    = in_word_i.data_byte;
  assign last = in_word_i.last_byte;
  assign cls  = lead_class(b);

  assign accum_n = {state_i.point_accum[14:0], b[5:0]};
  assign bad_n   = state_i.seq_bad | (cls != LC_CONT);
  assign left_n  = state_i.bytes_left - 3'd1;
  assign offs    = accum_n[19:0] - 20'h10000;

  always_comb begin
    state_o   = state_i;
    n_units_o = 2'd0;
    unit0_o   = '0;
    unit1_o   = '0;
    if (state_i.bytes_left == 3'd0) begin
      // awaiting a lead byte
      case (cls)
        LC_SINGLE: begin
          n_units_o = 2'd1;
          unit0_o   = '{code_unit: {8'h00, b}, run_end: 1'b1, string_end: last};
        end
        LC_CONT: begin
          n_units_o = 2'd1;
          unit0_o   = '{code_unit: UnitErr, run_end: 1'b1, string_end: last};
        end
        default: begin
          state_o.seq_bad = 1'b0;
          case (cls)
            LC_TWO: begin
              state_o.bytes_left  = 3'd1;
              state_o.point_accum = {16'd0, b[4:0]};
            end
            LC_THREE: begin
              state_o.bytes_left  = 3'd2;
              state_o.point_accum = {17'd0, b[3:0]};
            end
            LC_FOUR: begin
              state_o.bytes_left  = 3'd3;
              state_o.point_accum = {18'd0, b[2:0]};
            end
            default: begin
              state_o.bytes_left  = 3'd4;
              state_o.point_accum = '0;
              state_o.seq_bad     = 1'b1;
            end
          endcase
          if (last) begin
            state_o   = '0;
            n_units_o = 2'd1;
            unit0_o   = '{code_unit: UnitErr, run_end: 1'b1, string_end: 1'b1};
          end
        end
      endcase
    end else begin
      // follower byte
      state_o.bytes_left  = left_n;
      state_o.point_accum = accum_n;
      state_o.seq_bad     = bad_n;
      if (left_n != 3'd0) begin
        if (last) begin
          state_o   = '0;
          n_units_o = 2'd1;
          unit0_o   = '{code_unit: UnitErr, run_end: 1'b1, string_end: 1'b1};
        end
      end else begin
        state_o   = '0;
        n_units_o = 2'd1;
        if (bad_n || (accum_n[20:16] > 5'h10)) begin
          unit0_o = '{code_unit: UnitErr, run_end: 1'b1, string_end: last};
        end else if (accum_n[20:16] == 5'h00) begin
          unit0_o = '{code_unit: accum_n[15:0], run_end: 1'b1, string_end: last};
        end else begin
          n_units_o = 2'd2;
          unit0_o   = '{code_unit: {SurrHiPfx, offs[19:10]}, run_end: 1'b0,
                        string_end: 1'b0};
          unit1_o   = '{code_unit: {SurrLoPfx, offs[9:0]}, run_end: 1'b1,
                        string_end: last};
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/utf8_to_utf16_transcoder_top.sv]
`default_nettype none

// Words of an accepted byte are registered in the output buffer and leave from its head.
// Throughput: one byte per cycle while the buffer has room; bytes that only collect give no word.
// A surrogate pair fills two buffer slots, so input may stall after it.
// A three-word output buffer sets the figure: input is taken while two slots are free after this cycle's pop.
// Reset (rst_ni low, asynchronous) clears the sequence state and empties the buffer.
module utf8_to_utf16_transcoder_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  u8u16_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u8u16_pkg::out_word_t out_data_o
);
  import u8u16_pkg::*;

  localparam int unsigned BufDepth = 3;

  // Sequence state: followers still due, gathered code point bits, bad flag.
  seq_state_t state_q, state_d;

  // Output buffer, head always in slot 0, shifted down on every pop.
  out_word_t  slot_q [BufDepth];
  out_word_t  slot_d [BufDepth];
  logic [1:0] cnt_q, cnt_d;

  seq_state_t dec_state;
  logic [1:0] dec_n;
  out_word_t  dec_u0, dec_u1;

  logic       push, pop;
  logic [1:0] cnt_pop;

  u8u16_decode u_decode (
    .in_word_i (in_data_i),
    .state_i   (state_q),
    .state_o   (dec_state),
    .n_units_o (dec_n),
    .unit0_o   (dec_u0),
    .unit1_o   (dec_u1)
  );

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // Take a byte only if a surrogate pair would still fit after this cycle's pop.
  assign in_ready_o  = (cnt_q <= 2'd1) || ((cnt_q == 2'd2) && out_ready_i);
  assign push        = in_valid_i && in_ready_o;
  assign cnt_pop     = cnt_q - {1'b0, pop};

  assign state_d = push ? dec_state : state_q;

  always_comb begin
    cnt_d = push ? (cnt_pop + dec_n) : cnt_pop;
    for (int i = 0; i < BufDepth; i++) begin
      if (pop && (i < BufDepth - 1)) begin
        slot_d[i] = slot_q[i + 1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (push && (dec_n != 2'd0) && (i == int'(cnt_pop))) begin
        slot_d[i] = dec_u0;
      end
      if (push && (dec_n == 2'd2) && (i == int'(cnt_pop) + 1)) begin
        slot_d[i] = dec_u1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload slots carry no reset; the count guards them.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

`ifndef SYNTHESIS
  // Ready must never be offered while the buffer is full.
  a_no_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (cnt_q != 2'd3))
    else $error("input ready with full output buffer");

  // A sequence never announces more than four followers.
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bytes_left <= 3'd4)
    else $error("bytes_left out of range");

  // The last byte of a string always leaves the decoder awaiting a lead.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && in_data_i.last_byte) |=> (state_q == '0))
    else $error("sequence state not cleared at string end");

  // The last byte of a string always yields at least one word.
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && in_data_i.last_byte) |-> (dec_n != 2'd0))
    else $error("string end produced no word");
`endif

endmodule

`default_nettype wire
